FILE: hdl/tpr_pkg.sv
package tpr_pkg;

   localparam int PosWidth      = 32;
   localparam int VelWidth      = 21;
   localparam int DiffWidth     = PosWidth + 1;
   localparam int WindowWidth   = 20;
   localparam int SpeedWidth    = 20;
   localparam int StepWidth     = 16;
   localparam int DividerWidth  = 8;
   localparam int GainWidth     = 8;
   localparam int CsrIndexWidth = 3;
   localparam int CsrDataWidth  = 20;
   localparam int SquareWidth   = 2 * (VelWidth - 1) + 1;
   localparam int GainProdWidth = VelWidth - 1 + GainWidth;
   localparam int DivisorWidth  = StepWidth + 1;
   localparam int BrakeWidth    = SquareWidth;
   localparam int CompareWidth  = BrakeWidth + 2;
   localparam int ClampWidth    = VelWidth + 2;
   localparam int DivSteps      = SquareWidth;
   localparam int DivCountWidth = $clog2(DivSteps);

   localparam logic [PosWidth-1:0] PosMax = {1'b0, {(PosWidth-1){1'b1}}};
   localparam logic [PosWidth-1:0] PosMin = {1'b1, {(PosWidth-1){1'b0}}};

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_BYPASS            = 3'd0,
      CSR_ARRIVAL_WINDOW    = 3'd1,
      CSR_RATE_DIVIDER      = 3'd2,
      CSR_ACCEL_STEP        = 3'd3,
      CSR_DECEL_STEP        = 3'd4,
      CSR_SPEED_LIMIT_FWD   = 3'd5,
      CSR_SPEED_LIMIT_REV   = 3'd6,
      CSR_ANTICIPATION_GAIN = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic load_in;
      logic do_bypass;
      logic do_hold;
      logic start_update;
      logic mul_gain;
      logic div_step;
      logic brake;
      logic dir;
      logic clamp;
      logic setpt;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic bypass;
      logic hold;
   } status_type;

endpackage

FILE: hdl/tpr_controller.sv
module tpr_controller (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  tpr_pkg::status_type  status,
   output tpr_pkg::cmd_type     cmd
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_START,
      S_GAIN,
      S_DIV,
      S_BRAKE,
      S_DIR,
      S_CLAMP,
      S_SETPT,
      S_OUT
   } state_type;

   state_type                            state_ff;
   state_type                            state_in;
   logic [tpr_pkg::DivCountWidth-1:0]    count_ff;
   logic [tpr_pkg::DivCountWidth-1:0]    count_in;
   logic                                 rsp_valid_ff;
   logic                                 rsp_valid_in;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_in = 1'b1;
               state_in    = S_START;
            end
         end
         S_START: begin
            if (status.bypass) begin
               cmd.do_bypass = 1'b1;
               state_in      = S_OUT;
            end else if (status.hold) begin
               cmd.do_hold = 1'b1;
               state_in    = S_OUT;
            end else begin
               cmd.start_update = 1'b1;
               state_in         = S_GAIN;
            end
         end
         S_GAIN: begin
            cmd.mul_gain = 1'b1;
            count_in     = tpr_pkg::DivCountWidth'(tpr_pkg::DivSteps - 1);
            state_in     = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (count_ff == '0) begin
               state_in = S_BRAKE;
            end else begin
               count_in = count_ff - 1'b1;
            end
         end
         S_BRAKE: begin
            cmd.brake = 1'b1;
            state_in  = S_DIR;
         end
         S_DIR: begin
            cmd.dir  = 1'b1;
            state_in = S_CLAMP;
         end
         S_CLAMP: begin
            cmd.clamp = 1'b1;
            state_in  = S_SETPT;
         end
         S_SETPT: begin
            cmd.setpt = 1'b1;
            state_in  = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

FILE: hdl/tpr_datapath.sv
module tpr_datapath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  tpr_pkg::cmd_type                     cmd,
   output tpr_pkg::status_type                  status,
   input  logic signed [tpr_pkg::PosWidth-1:0]  req_target_position,
   input  logic signed [tpr_pkg::PosWidth-1:0]  req_measured_position,
   input  logic signed [tpr_pkg::VelWidth-1:0]  req_measured_velocity,
   input  logic                                 csr_write_enable,
   input  logic [tpr_pkg::CsrIndexWidth-1:0]    csr_index,
   input  logic [tpr_pkg::CsrDataWidth-1:0]     csr_write_data,
   output logic signed [tpr_pkg::PosWidth-1:0]  rsp_position_setpoint,
   output logic                                 rsp_arrived
);

   // Configuration registers.
   logic                                 bypass_ff;
   logic [tpr_pkg::WindowWidth-1:0]      window_ff;
   logic [tpr_pkg::DividerWidth-1:0]     divider_ff;
   logic [tpr_pkg::StepWidth-1:0]        accel_ff;
   logic [tpr_pkg::StepWidth-1:0]        decel_ff;
   logic [tpr_pkg::SpeedWidth-1:0]       fwd_ff;
   logic [tpr_pkg::SpeedWidth-1:0]       rev_ff;
   logic [tpr_pkg::GainWidth-1:0]        gain_ff;

   // State carried from item to item.
   logic [tpr_pkg::DividerWidth-1:0]     div_count_ff;
   logic [tpr_pkg::VelWidth-1:0]         vcmd_ff;
   logic [tpr_pkg::PosWidth-1:0]         last_ff;
   logic                                 arrived_ff;

   // Working registers of the current item.
   logic [tpr_pkg::PosWidth-1:0]         tgt_ff;
   logic [tpr_pkg::PosWidth-1:0]         pos_ff;
   logic                                 vel_neg_ff;
   logic [tpr_pkg::VelWidth-1:0]         absvel_ff;
   logic [tpr_pkg::DiffWidth-1:0]        diff_ff;
   logic [tpr_pkg::SquareWidth-1:0]      quo_ff;
   logic [tpr_pkg::DivisorWidth-1:0]     rem_ff;
   logic [tpr_pkg::GainProdWidth-1:0]    gprod_ff;
   logic [tpr_pkg::BrakeWidth-1:0]       brake_ff;
   logic                                 ge_ff;
   logic [tpr_pkg::PosWidth-1:0]         res_ff;
   logic [tpr_pkg::PosWidth-1:0]         rsp_pos_ff;
   logic                                 rsp_arrived_ff;

   logic [tpr_pkg::VelWidth-1:0]         absvel_in;
   logic [tpr_pkg::DiffWidth-1:0]        diff_in;
   logic [tpr_pkg::DiffWidth-1:0]        absdiff;
   logic                                 in_window;
   logic [tpr_pkg::SquareWidth-1:0]      square_full;
   logic [tpr_pkg::GainProdWidth-1:0]    gprod_full;
   logic [tpr_pkg::DivisorWidth-1:0]     divisor;
   logic [tpr_pkg::DivisorWidth:0]       shifted;
   logic [tpr_pkg::DivisorWidth+1:0]     trial;
   logic                                 qbit;
   logic [tpr_pkg::DivisorWidth-1:0]     rem_in;
   logic [tpr_pkg::BrakeWidth-1:0]       brake_in;
   logic [tpr_pkg::CompareWidth-1:0]     diff_ext;
   logic [tpr_pkg::CompareWidth-1:0]     brake_ext;
   logic [tpr_pkg::CompareWidth-1:0]     margin;
   logic                                 ge_in;
   logic [tpr_pkg::ClampWidth-1:0]       vc_sum;
   logic [tpr_pkg::ClampWidth-1:0]       vc_step;
   logic [tpr_pkg::ClampWidth-1:0]       neg_rev;
   logic [tpr_pkg::ClampWidth-1:0]       fwd_ext;
   logic [tpr_pkg::VelWidth-1:0]         vcmd_in;
   logic [tpr_pkg::DiffWidth-1:0]        sp_sum;
   logic [tpr_pkg::PosWidth-1:0]         sp_in;

   assign absvel_in = req_measured_velocity[tpr_pkg::VelWidth-1]
                      ? (tpr_pkg::VelWidth'(0) - req_measured_velocity)
                      : req_measured_velocity;
   assign diff_in   = {req_target_position[tpr_pkg::PosWidth-1], req_target_position}
                      - {req_measured_position[tpr_pkg::PosWidth-1], req_measured_position};

   assign absdiff   = diff_ff[tpr_pkg::DiffWidth-1] ? (tpr_pkg::DiffWidth'(0) - diff_ff)
                                                     : diff_ff;
   assign in_window = absdiff < tpr_pkg::DiffWidth'(window_ff);

   assign status.bypass = bypass_ff;
   assign status.hold   = (divider_ff > tpr_pkg::DividerWidth'(1))
                          && (div_count_ff > tpr_pkg::DividerWidth'(1));

   assign square_full = tpr_pkg::SquareWidth'(absvel_ff) * tpr_pkg::SquareWidth'(absvel_ff);
   assign gprod_full  = tpr_pkg::GainProdWidth'(absvel_ff) * tpr_pkg::GainProdWidth'(gain_ff);

   // Restoring division of the squared velocity by twice the deceleration.
   assign divisor = {((decel_ff == '0) ? tpr_pkg::StepWidth'(1) : decel_ff), 1'b0};
   assign shifted = {rem_ff, quo_ff[tpr_pkg::SquareWidth-1]};
   assign trial   = {1'b0, shifted} - {2'b00, divisor};
   assign qbit    = !trial[tpr_pkg::DivisorWidth+1];
   assign rem_in  = qbit ? trial[tpr_pkg::DivisorWidth-1:0]
                         : shifted[tpr_pkg::DivisorWidth-1:0];

   assign brake_in = quo_ff + tpr_pkg::BrakeWidth'(gprod_ff);

   assign diff_ext  = {{(tpr_pkg::CompareWidth-tpr_pkg::DiffWidth){diff_ff[tpr_pkg::DiffWidth-1]}},
                       diff_ff};
   assign brake_ext = tpr_pkg::CompareWidth'(brake_ff);
   assign margin    = vel_neg_ff ? (diff_ext + brake_ext) : (diff_ext - brake_ext);
   assign ge_in     = !margin[tpr_pkg::CompareWidth-1];

   assign vc_step = ge_ff ? tpr_pkg::ClampWidth'(accel_ff)
                          : (tpr_pkg::ClampWidth'(0) - tpr_pkg::ClampWidth'(decel_ff));
   assign vc_sum  = {{2{vcmd_ff[tpr_pkg::VelWidth-1]}}, vcmd_ff} + vc_step;
   assign neg_rev = tpr_pkg::ClampWidth'(0) - tpr_pkg::ClampWidth'(rev_ff);
   assign fwd_ext = tpr_pkg::ClampWidth'(fwd_ff);

   always_comb begin
      if ($signed(vc_sum) < $signed(neg_rev)) begin
         vcmd_in = neg_rev[tpr_pkg::VelWidth-1:0];
      end else if ($signed(vc_sum) > $signed(fwd_ext)) begin
         vcmd_in = fwd_ext[tpr_pkg::VelWidth-1:0];
      end else begin
         vcmd_in = vc_sum[tpr_pkg::VelWidth-1:0];
      end
   end

   assign sp_sum = {pos_ff[tpr_pkg::PosWidth-1], pos_ff}
                   + {{(tpr_pkg::DiffWidth-tpr_pkg::VelWidth){vcmd_ff[tpr_pkg::VelWidth-1]}},
                      vcmd_ff};

   always_comb begin
      if (sp_sum[tpr_pkg::DiffWidth-1] != sp_sum[tpr_pkg::PosWidth-1]) begin
         sp_in = sp_sum[tpr_pkg::DiffWidth-1] ? tpr_pkg::PosMin : tpr_pkg::PosMax;
      end else begin
         sp_in = sp_sum[tpr_pkg::PosWidth-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bypass_ff  <= 1'b0;
         window_ff  <= '0;
         divider_ff <= '0;
         accel_ff   <= '0;
         decel_ff   <= tpr_pkg::StepWidth'(1);
         fwd_ff     <= '0;
         rev_ff     <= '0;
         gain_ff    <= '0;
      end else if (csr_write_enable) begin
         case (tpr_pkg::csr_index_type'(csr_index))
            tpr_pkg::CSR_BYPASS:            bypass_ff  <= csr_write_data[0];
            tpr_pkg::CSR_ARRIVAL_WINDOW:    window_ff  <= csr_write_data;
            tpr_pkg::CSR_RATE_DIVIDER:      divider_ff <= csr_write_data[tpr_pkg::DividerWidth-1:0];
            tpr_pkg::CSR_ACCEL_STEP:        accel_ff   <= csr_write_data[tpr_pkg::StepWidth-1:0];
            tpr_pkg::CSR_DECEL_STEP:        decel_ff   <= csr_write_data[tpr_pkg::StepWidth-1:0];
            tpr_pkg::CSR_SPEED_LIMIT_FWD:   fwd_ff     <= csr_write_data;
            tpr_pkg::CSR_SPEED_LIMIT_REV:   rev_ff     <= csr_write_data;
            tpr_pkg::CSR_ANTICIPATION_GAIN: gain_ff    <= csr_write_data[tpr_pkg::GainWidth-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_count_ff <= '0;
         vcmd_ff      <= '0;
         last_ff      <= '0;
         arrived_ff   <= 1'b0;
      end else begin
         if (cmd.do_bypass && in_window) begin
            arrived_ff <= 1'b1;
         end
         if (cmd.do_hold) begin
            div_count_ff <= div_count_ff - 1'b1;
         end
         if (cmd.start_update) begin
            arrived_ff <= 1'b0;
            if (divider_ff > tpr_pkg::DividerWidth'(1)) begin
               div_count_ff <= divider_ff;
            end
         end
         if (cmd.clamp) begin
            vcmd_ff <= vcmd_in;
         end
         if (cmd.setpt) begin
            if (in_window) begin
               arrived_ff <= 1'b1;
            end else begin
               last_ff <= sp_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         tgt_ff     <= req_target_position;
         pos_ff     <= req_measured_position;
         vel_neg_ff <= req_measured_velocity[tpr_pkg::VelWidth-1];
         absvel_ff  <= absvel_in;
         diff_ff    <= diff_in;
      end
      if (cmd.start_update) begin
         quo_ff <= square_full;
      end
      if (cmd.mul_gain) begin
         gprod_ff <= gprod_full;
         rem_ff   <= '0;
      end
      if (cmd.div_step) begin
         quo_ff <= {quo_ff[tpr_pkg::SquareWidth-2:0], qbit};
         rem_ff <= rem_in;
      end
      if (cmd.brake) begin
         brake_ff <= brake_in;
      end
      if (cmd.dir) begin
         ge_ff <= ge_in;
      end
      if (cmd.do_bypass) begin
         res_ff <= tgt_ff;
      end
      if (cmd.do_hold) begin
         res_ff <= last_ff;
      end
      if (cmd.setpt) begin
         res_ff <= in_window ? tgt_ff : sp_in;
      end
      if (cmd.load_out) begin
         rsp_pos_ff     <= res_ff;
         rsp_arrived_ff <= arrived_ff;
      end
   end

   assign rsp_position_setpoint = rsp_pos_ff;
   assign rsp_arrived           = rsp_arrived_ff;

endmodule

FILE: hdl/trapezoid_position_ramp.sv
// Bypassed and held items pass through the START and OUT states after acceptance; updates
// pass through START, GAIN, DIV, BRAKE, DIR, CLAMP, SETPT and OUT. One item is handled at a time.
// Most of an update is spent in the braking-distance divider, which retires one quotient
// bit per cycle. A waiting result does not stop the next item's acceptance.
// Reset is synchronous: configuration registers return to their defaults and all ramp state is cleared.
module trapezoid_position_ramp (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [tpr_pkg::PosWidth-1:0]  req_target_position,
   input  logic signed [tpr_pkg::PosWidth-1:0]  req_measured_position,
   input  logic signed [tpr_pkg::VelWidth-1:0]  req_measured_velocity,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [tpr_pkg::PosWidth-1:0]  rsp_position_setpoint,
   output logic                                 rsp_arrived,
   input  logic                                 csr_write_enable,
   input  logic [tpr_pkg::CsrIndexWidth-1:0]    csr_index,
   input  logic [tpr_pkg::CsrDataWidth-1:0]     csr_write_data
);

   tpr_pkg::cmd_type    cmd;
   tpr_pkg::status_type status;

   tpr_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   tpr_datapath u_datapath (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .status                (status),
      .req_target_position   (req_target_position),
      .req_measured_position (req_measured_position),
      .req_measured_velocity (req_measured_velocity),
      .csr_write_enable      (csr_write_enable),
      .csr_index             (csr_index),
      .csr_write_data        (csr_write_data),
      .rsp_position_setpoint (rsp_position_setpoint),
      .rsp_arrived           (rsp_arrived)
   );

endmodule

FILE: hdl/tpr_checker.sv
module tpr_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic signed [tpr_pkg::PosWidth-1:0] rsp_position_setpoint,
   input logic                                rsp_arrived
);

   // A stalled item keeps its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_position_setpoint)
                                  && $stable(rsp_arrived))
      else $error("stalled item changed or was dropped");

   // Leaving reset, no item is offered and the block is ready.
   assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid && req_ready)
      else $error("wrong handshake state after reset");

   // No new item is accepted straight after the previous one: req_ready stays low after each acceptance.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready ##1 !req_ready)
      else $error("item accepted while the previous one was in progress");

endmodule

bind trapezoid_position_ramp tpr_checker u_tpr_checker (.*);
